// ----- rtl/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, command and status types for the twister generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

   // generator geometry
   localparam int unsigned TW_N  = 624;
   localparam int unsigned TW_M  = 397;
   localparam int unsigned IDX_W = 10;

   // twist and seeding constants
   localparam logic [31:0] TW_MATRIX   = 32'h9908_b0df;
   localparam logic [31:0] TW_UPPER    = 32'h8000_0000;
   localparam logic [31:0] TW_LOWER    = 32'h7fff_ffff;
   localparam logic [31:0] MUL_INIT    = 32'd1812433253;
   localparam logic [31:0] MUL_MIX1    = 32'd1664525;
   localparam logic [31:0] MUL_MIX2    = 32'd1566083941;
   localparam logic [31:0] SEED_ARRAY  = 32'd19650218;
   localparam logic [31:0] SEED_DEFLT  = 32'd5489;
   localparam logic [31:0] FINAL_WORD0 = 32'h8000_0000;
   localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_GEN  = 1'b1;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BS_INIT,
      ST_BS_MUL,
      ST_BS_WR,
      ST_MIX1_INIT,
      ST_MIX1_RD,
      ST_MIX1_WR,
      ST_MIX2_INIT,
      ST_MIX2_RD,
      ST_MIX2_WR,
      ST_FIN,
      ST_TW_INIT,
      ST_TW_PRIME,
      ST_TW_RD,
      ST_TW_WR,
      ST_GEN_RD,
      ST_GEN_WR
   } ctrl_state_type;

   // datapath operations
   typedef enum logic [4:0] {
      DP_IDLE,
      DP_BS_INIT,
      DP_BS_MUL,
      DP_BS_WR,
      DP_MIX1_INIT,
      DP_MIX1_RD,
      DP_MIX1_WR,
      DP_MIX2_INIT,
      DP_MIX2_RD,
      DP_MIX2_WR,
      DP_FIN,
      DP_TW_INIT,
      DP_TW_PRIME,
      DP_TW_RD,
      DP_TW_WR,
      DP_GEN_RD,
      DP_GEN_WR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      seed_array;
      logic      key_write;
      logic      key_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic n_last;
      logic steps_last;
      logic idx_full;
      logic seeded;
      logic out_free;
   } dp_stat_type;

endpackage

// ----- rtl/mtg_req_if.sv -----
// ----------------------------------------------------------------------------
// mtg_req_if
// Request channel: function code, key word and last-key marker.
// ----------------------------------------------------------------------------
interface mtg_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] key_word;
   logic        key_last;

   modport source (output valid, output func, output key_word, output key_last,
                   input ready);
   modport sink   (input valid, input func, input key_word, input key_last,
                   output ready);
endinterface

// ----- rtl/mtg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mtg_rsp_if
// Response channel: one tempered random word per transaction.
// ----------------------------------------------------------------------------
interface mtg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rand_word;

   modport source (output valid, output rand_word, input ready);
   modport sink   (input valid, input rand_word, output ready);
endinterface

// ----- rtl/mtg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mtg_ctrl
// Sequencer for seeding, twisting and word generation.
// ----------------------------------------------------------------------------
module mtg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   input  logic                 req_key_last,
   output logic                 req_ready,
   input  mtg_pkg::dp_stat_type stat,
   output mtg_pkg::dp_cmd_type  cmd
);

   mtg_pkg::ctrl_state_type state_ff, state_in;
   logic                    array_ff, array_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtg_pkg::ST_IDLE;
         array_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         array_ff <= array_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      array_in = array_ff;
      unique case (state_ff)
         mtg_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_func == mtg_pkg::FUNC_GEN) begin
                  if (!stat.idx_full) begin
                     state_in = mtg_pkg::ST_GEN_RD;
                  end else if (stat.seeded) begin
                     state_in = mtg_pkg::ST_TW_INIT;
                  end else begin
                     state_in = mtg_pkg::ST_BS_INIT;
                     array_in = 1'b0;
                  end
               end else if (req_key_last) begin
                  state_in = mtg_pkg::ST_BS_INIT;
                  array_in = 1'b1;
               end
            end
         end
         mtg_pkg::ST_BS_INIT:   state_in = mtg_pkg::ST_BS_MUL;
         mtg_pkg::ST_BS_MUL:    state_in = mtg_pkg::ST_BS_WR;
         mtg_pkg::ST_BS_WR: begin
            if (!stat.n_last) begin
               state_in = mtg_pkg::ST_BS_MUL;
            end else if (array_ff) begin
               state_in = mtg_pkg::ST_MIX1_INIT;
            end else begin
               state_in = mtg_pkg::ST_TW_INIT;
            end
         end
         mtg_pkg::ST_MIX1_INIT: state_in = mtg_pkg::ST_MIX1_RD;
         mtg_pkg::ST_MIX1_RD:   state_in = mtg_pkg::ST_MIX1_WR;
         mtg_pkg::ST_MIX1_WR: begin
            state_in = stat.steps_last ? mtg_pkg::ST_MIX2_INIT : mtg_pkg::ST_MIX1_RD;
         end
         mtg_pkg::ST_MIX2_INIT: state_in = mtg_pkg::ST_MIX2_RD;
         mtg_pkg::ST_MIX2_RD:   state_in = mtg_pkg::ST_MIX2_WR;
         mtg_pkg::ST_MIX2_WR: begin
            state_in = stat.steps_last ? mtg_pkg::ST_FIN : mtg_pkg::ST_MIX2_RD;
         end
         mtg_pkg::ST_FIN:       state_in = mtg_pkg::ST_IDLE;
         mtg_pkg::ST_TW_INIT:   state_in = mtg_pkg::ST_TW_PRIME;
         mtg_pkg::ST_TW_PRIME:  state_in = mtg_pkg::ST_TW_RD;
         mtg_pkg::ST_TW_RD:     state_in = mtg_pkg::ST_TW_WR;
         mtg_pkg::ST_TW_WR: begin
            state_in = stat.n_last ? mtg_pkg::ST_GEN_RD : mtg_pkg::ST_TW_RD;
         end
         mtg_pkg::ST_GEN_RD:    state_in = mtg_pkg::ST_GEN_WR;
         mtg_pkg::ST_GEN_WR: begin
            if (stat.out_free) begin
               state_in = mtg_pkg::ST_IDLE;
            end
         end
         default:               state_in = mtg_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd.op         = mtg_pkg::DP_IDLE;
      cmd.seed_array = array_ff;
      cmd.key_write  = 1'b0;
      cmd.key_clear  = 1'b0;
      unique case (state_ff)
         mtg_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.key_write = req_valid && (req_func == mtg_pkg::FUNC_LOAD);
         end
         mtg_pkg::ST_BS_INIT:   cmd.op = mtg_pkg::DP_BS_INIT;
         mtg_pkg::ST_BS_MUL:    cmd.op = mtg_pkg::DP_BS_MUL;
         mtg_pkg::ST_BS_WR:     cmd.op = mtg_pkg::DP_BS_WR;
         mtg_pkg::ST_MIX1_INIT: cmd.op = mtg_pkg::DP_MIX1_INIT;
         mtg_pkg::ST_MIX1_RD:   cmd.op = mtg_pkg::DP_MIX1_RD;
         mtg_pkg::ST_MIX1_WR:   cmd.op = mtg_pkg::DP_MIX1_WR;
         mtg_pkg::ST_MIX2_INIT: cmd.op = mtg_pkg::DP_MIX2_INIT;
         mtg_pkg::ST_MIX2_RD:   cmd.op = mtg_pkg::DP_MIX2_RD;
         mtg_pkg::ST_MIX2_WR:   cmd.op = mtg_pkg::DP_MIX2_WR;
         mtg_pkg::ST_FIN: begin
            cmd.op        = mtg_pkg::DP_FIN;
            cmd.key_clear = 1'b1;
         end
         mtg_pkg::ST_TW_INIT:   cmd.op = mtg_pkg::DP_TW_INIT;
         mtg_pkg::ST_TW_PRIME:  cmd.op = mtg_pkg::DP_TW_PRIME;
         mtg_pkg::ST_TW_RD:     cmd.op = mtg_pkg::DP_TW_RD;
         mtg_pkg::ST_TW_WR:     cmd.op = mtg_pkg::DP_TW_WR;
         mtg_pkg::ST_GEN_RD:    cmd.op = mtg_pkg::DP_GEN_RD;
         mtg_pkg::ST_GEN_WR:    cmd.op = mtg_pkg::DP_GEN_WR;
         default:               cmd.op = mtg_pkg::DP_IDLE;
      endcase
   end

endmodule

// ----- rtl/mtg_datapath.sv -----
// ----------------------------------------------------------------------------
// mtg_datapath
// State memory, key store, shared multiplier, counters and output register.
// ----------------------------------------------------------------------------
module mtg_datapath #(
   parameter int unsigned MAX_KEY_WORDS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mtg_pkg::dp_cmd_type  cmd,
   output mtg_pkg::dp_stat_type stat,
   input  logic [31:0]          req_key_word,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_rand_word
);

   localparam int unsigned KIW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
   localparam int unsigned KCW = $clog2(MAX_KEY_WORDS + 1);
   localparam int unsigned IW  = mtg_pkg::IDX_W;

   localparam logic [IW-1:0] N_LAST    = IW'(mtg_pkg::TW_N - 1);
   localparam logic [IW-1:0] N_FULL    = IW'(mtg_pkg::TW_N);
   localparam logic [IW-1:0] M_OFS     = IW'(mtg_pkg::TW_M);
   localparam logic [IW-1:0] NM_OFS    = IW'(mtg_pkg::TW_N - mtg_pkg::TW_M);
   localparam logic [IW-1:0] MIX1_STEP = IW'(mtg_pkg::TW_N);
   localparam logic [IW-1:0] MIX2_STEP = IW'(mtg_pkg::TW_N - 1);

   // output tempering
   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
      y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   logic [31:0]    tw_mem [mtg_pkg::TW_N];
   logic [31:0]    key_mem [MAX_KEY_WORDS];

   logic [IW-1:0]  n_ff, n_in;
   logic [IW-1:0]  steps_ff, steps_in;
   logic [IW-1:0]  index_ff, index_in;
   logic [KIW-1:0] b_ff, b_in;
   logic [KCW-1:0] key_count_ff, key_count_in;
   logic           seeded_ff, seeded_in;
   logic [31:0]    prev_ff, prev_in;
   logic [31:0]    cur_ff, cur_in;
   logic [31:0]    prod_ff, prod_in;
   logic [31:0]    rd_a_ff, rd_b_ff, key_rd_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_word_ff, rsp_word_in;

   logic [IW-1:0]  addr_a, addr_b, wr_addr;
   logic           wr_en;
   logic [31:0]    wr_data;
   logic [31:0]    mul_src, mul_const;
   logic [63:0]    prod_full;
   logic [31:0]    mix_word, twist_y, twist_word;
   logic [IW-1:0]  n_wrap, n_nx, n_far;
   logic [KCW-1:0] b_plus;
   logic           out_free, key_room;

   // status towards the controller
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign key_room        = key_count_ff < KCW'(MAX_KEY_WORDS);
   assign stat.n_last     = n_ff == N_LAST;
   assign stat.steps_last = steps_ff == IW'(1);
   assign stat.idx_full   = index_ff >= N_FULL;
   assign stat.seeded     = seeded_ff;
   assign stat.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rand_word = rsp_word_ff;

   // index helpers for mixing and twisting
   assign n_wrap = (n_ff == N_LAST) ? IW'(1) : n_ff + IW'(1);
   assign n_nx   = (n_ff == N_LAST) ? '0 : n_ff + IW'(1);
   assign n_far  = (n_ff < NM_OFS) ? n_ff + M_OFS : n_ff - NM_OFS;
   assign b_plus = KCW'(b_ff) + KCW'(1);

   // shared multiplier, registered
   assign mul_src   = prev_ff ^ (prev_ff >> 30);
   assign prod_full = mul_src * mul_const;
   assign prod_in   = prod_full[31:0];

   always_comb begin
      case (cmd.op)
         mtg_pkg::DP_MIX1_RD: mul_const = mtg_pkg::MUL_MIX1;
         mtg_pkg::DP_MIX2_RD: mul_const = mtg_pkg::MUL_MIX2;
         default:             mul_const = mtg_pkg::MUL_INIT;
      endcase
   end

   // twist of one word
   assign twist_y    = (cur_ff & mtg_pkg::TW_UPPER) | (rd_a_ff & mtg_pkg::TW_LOWER);
   assign twist_word = rd_b_ff ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::TW_MATRIX : '0);
   assign mix_word   = rd_a_ff ^ prod_ff;

   // memory addressing, write data and counter updates
   always_comb begin
      addr_a       = index_ff;
      addr_b       = n_far;
      wr_en        = 1'b0;
      wr_addr      = n_ff;
      wr_data      = '0;
      n_in         = n_ff;
      steps_in     = steps_ff;
      index_in     = index_ff;
      b_in         = b_ff;
      seeded_in    = seeded_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         mtg_pkg::DP_BS_INIT: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = cmd.seed_array ? mtg_pkg::SEED_ARRAY : mtg_pkg::SEED_DEFLT;
            prev_in   = wr_data;
            n_in      = IW'(1);
            index_in  = N_FULL;
            seeded_in = 1'b1;
         end
         mtg_pkg::DP_BS_WR: begin
            wr_en   = 1'b1;
            wr_data = prod_ff + 32'(n_ff);
            prev_in = wr_data;
            n_in    = n_ff + IW'(1);
         end
         mtg_pkg::DP_MIX1_INIT: begin
            prev_in  = mtg_pkg::SEED_ARRAY;
            n_in     = IW'(1);
            b_in     = '0;
            steps_in = MIX1_STEP;
         end
         mtg_pkg::DP_MIX1_RD, mtg_pkg::DP_MIX2_RD: begin
            addr_a = n_ff;
         end
         mtg_pkg::DP_MIX1_WR: begin
            wr_en    = 1'b1;
            wr_data  = mix_word + key_rd_ff + 32'(b_ff);
            prev_in  = wr_data;
            n_in     = n_wrap;
            b_in     = (b_plus >= key_count_ff) ? '0 : b_plus[KIW-1:0];
            steps_in = steps_ff - IW'(1);
         end
         mtg_pkg::DP_MIX2_INIT: begin
            steps_in = MIX2_STEP;
         end
         mtg_pkg::DP_MIX2_WR: begin
            wr_en    = 1'b1;
            wr_data  = mix_word - 32'(n_ff);
            prev_in  = wr_data;
            n_in     = n_wrap;
            steps_in = steps_ff - IW'(1);
         end
         mtg_pkg::DP_FIN: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = mtg_pkg::FINAL_WORD0;
            index_in = N_FULL;
         end
         mtg_pkg::DP_TW_INIT: begin
            addr_a = '0;
            n_in   = '0;
         end
         mtg_pkg::DP_TW_PRIME: begin
            cur_in = rd_a_ff;
         end
         mtg_pkg::DP_TW_RD: begin
            addr_a = n_nx;
         end
         mtg_pkg::DP_TW_WR: begin
            wr_en   = 1'b1;
            wr_data = twist_word;
            cur_in  = rd_a_ff;
            n_in    = n_ff + IW'(1);
            if (n_ff == N_LAST) begin
               index_in = '0;
            end
         end
         mtg_pkg::DP_GEN_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = temper(rd_a_ff);
               index_in     = index_ff + IW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // key store count
   always_comb begin
      key_count_in = key_count_ff;
      if (cmd.key_clear) begin
         key_count_in = '0;
      end else if (cmd.key_write && key_room) begin
         key_count_in = key_count_ff + KCW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= N_FULL;
         seeded_ff    <= 1'b0;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         seeded_ff    <= seeded_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      steps_ff    <= steps_in;
      b_ff        <= b_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      prod_ff     <= prod_in;
      rsp_word_ff <= rsp_word_in;
   end

   // state memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tw_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= tw_mem[addr_a];
      rd_b_ff <= tw_mem[addr_b];
   end

   // key store, registered read
   always_ff @(posedge clock) begin
      if (cmd.key_write && key_room) begin
         key_mem[key_count_ff[KIW-1:0]] <= req_key_word;
      end
      key_rd_ff <= key_mem[b_ff];
   end

endmodule

// ----- rtl/mersenne_twister_generator.sv -----
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// 32-bit MT19937 generator with key-array seeding and tempered output.
// ----------------------------------------------------------------------------
// A load transaction (func 0) appends one key word to the key store; words
// past MAX_KEY_WORDS are dropped. A load marked key_last reseeds the state
// from the held key through a basic seed, a first mixing pass, a second pass
// and a final write, paced by the single write port of the 624-word state
// memory and the one shared 32x32 multiplier, each word passing through a
// multiply state and a write state. A generate transaction (func 1) reads
// its word from the state memory, then tempers it into the output register,
// which waits while the previous response is still held on the response
// channel; when all 624 words have been used, a twist (a read state and a
// write state per word on the state memory) comes first, and a generate
// before any seeding adds a default seed. The next request is taken while
// the last result still waits on the response channel.
module mersenne_twister_generator #(
   parameter int unsigned MAX_KEY_WORDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   mtg_req_if.sink     req_if,
   mtg_rsp_if.source   rsp_if
);

   mtg_pkg::dp_cmd_type  dp_cmd;
   mtg_pkg::dp_stat_type dp_stat;
   logic                 req_ready;
   logic                 rsp_valid;
   logic [31:0]          rsp_word;

   assign req_if.ready     = req_ready;
   assign rsp_if.valid     = rsp_valid;
   assign rsp_if.rand_word = rsp_word;

   // sequencer
   mtg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_func     (req_if.func),
      .req_key_last (req_if.key_last),
      .req_ready    (req_ready),
      .stat         (dp_stat),
      .cmd          (dp_cmd)
   );

   // datapath
   mtg_datapath #(
      .MAX_KEY_WORDS (MAX_KEY_WORDS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (dp_cmd),
      .stat          (dp_stat),
      .req_key_word  (req_if.key_word),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_valid),
      .rsp_rand_word (rsp_word)
   );

   // a generate transaction always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_ready && (req_if.func == mtg_pkg::FUNC_GEN)) |=> !req_ready)
      else $error("generate transaction did not start work");

   // a last key word always starts seeding
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_ready && (req_if.func == mtg_pkg::FUNC_LOAD) && req_if.key_last)
      |=> !req_ready)
      else $error("last key word did not start seeding");

   // words are read only from a seeded, unexhausted state
   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == mtg_pkg::DP_GEN_RD) |-> (dp_stat.seeded && !dp_stat.idx_full))
      else $error("output word read from unseeded or exhausted state");

   // a response appears only from the output load step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(dp_cmd.op) == mtg_pkg::DP_GEN_WR))
      else $error("response raised outside output load");

endmodule
